/* rtl/core/utf8sd_pkg.sv */
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Types, constants and decode helpers for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8sd_pkg;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned LenWidth = 3;

  localparam logic [CpWidth-1:0] UnicodeLimit  = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SurrogateLow  = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrogateHigh = 21'h00DFFF;
  localparam logic [CpWidth-1:0] NoncharLow    = 21'h00FDD0;
  localparam logic [CpWidth-1:0] NoncharHigh   = 21'h00FDEF;

  localparam logic [7:0] ContMask    = 8'hC0;
  localparam logic [7:0] ContPattern = 8'h80;

  localparam logic [LenWidth-1:0] LenNone = 3'd0;
  localparam logic [LenWidth-1:0] LenOne  = 3'd1;
  localparam logic [LenWidth-1:0] LenTwo  = 3'd2;
  localparam logic [LenWidth-1:0] LenThree = 3'd3;
  localparam logic [LenWidth-1:0] LenFour = 3'd4;

  typedef enum logic [2:0] {
    KIND_NONE        = 3'd0,
    KIND_BAD_LEAD    = 3'd1,
    KIND_TRUNCATED   = 3'd2,
    KIND_BAD_CONT    = 3'd3,
    KIND_TOO_LARGE   = 3'd4,
    KIND_SURROGATE   = 3'd5,
    KIND_NONCHAR_FDD = 3'd6,
    KIND_NONCHAR_END = 3'd7
  } err_kind_t;

  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic [LenWidth-1:0] seq_length;
    logic                error_flag;
    err_kind_t           error_kind;
  } result_t;

  // Sequence length implied by a lead byte; zero for an invalid lead.
  function automatic logic [LenWidth-1:0] lead_length(input logic [7:0] b);
    logic [LenWidth-1:0] len;
    if (b == 8'h00)      len = LenNone;
    else if (b < 8'h80)  len = LenOne;
    else if (b < 8'hC2)  len = LenNone;
    else if (b < 8'hE0)  len = LenTwo;
    else if (b < 8'hF0)  len = LenThree;
    else if (b < 8'hF5)  len = LenFour;
    else                 len = LenNone;
    return len;
  endfunction

  function automatic result_t make_error(input err_kind_t kind);
    result_t r;
    r.code_point = '0;
    r.seq_length = LenNone;
    r.error_flag = 1'b1;
    r.error_kind = kind;
    return r;
  endfunction

  // Range checks on a completed value, in priority order.
  function automatic result_t finish(input logic [CpWidth-1:0] value,
                                     input logic [LenWidth-1:0] len);
    result_t r;
    if (value > UnicodeLimit)
      r = make_error(KIND_TOO_LARGE);
    else if (value >= SurrogateLow && value <= SurrogateHigh)
      r = make_error(KIND_SURROGATE);
    else if (value >= NoncharLow && value <= NoncharHigh)
      r = make_error(KIND_NONCHAR_FDD);
    else if (&value[15:1])
      r = make_error(KIND_NONCHAR_END);
    else begin
      r.code_point = value;
      r.seq_length = len;
      r.error_flag = 1'b0;
      r.error_kind = KIND_NONE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/utf8_stream_decoder.sv */
// A result enters the result register (or the skid entry while the output
//   stalls) when the byte ending its sequence (or raising its error) is taken.
// Throughput: one byte per cycle while in_ready is high; the decode is a
//   single pass of shift, OR and range compares between the sequence state
//   and the result register. A skid entry catches one more result while one
//   waits; in_ready is low while it is full. rst (synchronous) idles all.
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder: one byte in per transaction, at most one code
// point or error out per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder
  import utf8sd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // byte channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          data_byte,
  input  wire logic                end_of_data,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [CpWidth-1:0]       code_point,
  output logic [LenWidth-1:0]      seq_length,
  output logic                     error_flag,
  output logic [2:0]               error_kind
);

  // Sequence state: continuation bytes still owed, partial value, length.
  logic [1:0]          bytes_left;
  logic [1:0]          bytes_left_next;
  logic [CpWidth-1:0]  acc;
  logic [CpWidth-1:0]  acc_next;
  logic [LenWidth-1:0] exp_len;
  logic [LenWidth-1:0] exp_len_next;

  // Result register and skid entry.
  result_t res;
  result_t skid;
  logic    skid_valid;

  result_t             res_new;
  logic                produce;
  logic                in_accept;
  logic [LenWidth-1:0] lead_len;
  logic [CpWidth-1:0]  acc_shift;
  logic [1:0]          left_dec;

  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;
  assign lead_len  = lead_length(data_byte);
  assign acc_shift = {acc[CpWidth-7:0], data_byte[5:0]};
  assign left_dec  = bytes_left - 2'd1;

  // Decode of one byte against the current sequence state.
  always_comb begin
    produce         = 1'b0;
    res_new         = make_error(KIND_NONE);
    bytes_left_next = 2'd0;
    acc_next        = acc;
    exp_len_next    = LenNone;
    if (bytes_left == 2'd0) begin
      // idle: this byte is a lead
      if (lead_len == LenNone) begin
        produce = 1'b1;
        res_new = make_error(KIND_BAD_LEAD);
      end else if (lead_len == LenOne) begin
        produce = 1'b1;
        res_new = finish({{(CpWidth-8){1'b0}}, data_byte}, LenOne);
      end else if (end_of_data) begin
        produce = 1'b1;
        res_new = make_error(KIND_TRUNCATED);
      end else begin
        bytes_left_next = lead_len[1:0] - 2'd1;
        exp_len_next    = lead_len;
        case (lead_len)
          LenTwo:   acc_next = {{(CpWidth-5){1'b0}}, data_byte[4:0]};
          LenThree: acc_next = {{(CpWidth-4){1'b0}}, data_byte[3:0]};
          default:  acc_next = {{(CpWidth-3){1'b0}}, data_byte[2:0]};
        endcase
      end
    end else if ((data_byte & ContMask) != ContPattern) begin
      // bad continuation: byte dropped, back to idle
      produce = 1'b1;
      res_new = make_error(KIND_BAD_CONT);
    end else if (left_dec == 2'd0) begin
      produce = 1'b1;
      res_new = finish(acc_shift, exp_len);
    end else if (end_of_data) begin
      produce = 1'b1;
      res_new = make_error(KIND_TRUNCATED);
    end else begin
      bytes_left_next = left_dec;
      acc_next        = acc_shift;
      exp_len_next    = exp_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= 2'd0;
      exp_len    <= LenNone;
    end else if (in_accept) begin
      bytes_left <= bytes_left_next;
      exp_len    <= exp_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      acc <= acc_next;
    end
  end

  // Output side: result register drains first, skid catches one more.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || (in_accept && produce);
      skid_valid <= 1'b0;
    end else if (in_accept && produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      res <= skid_valid ? skid : res_new;
    end else if (in_accept && produce) begin
      skid <= res_new;
    end
  end

  assign code_point = res.code_point;
  assign seq_length = res.seq_length;
  assign error_flag = res.error_flag;
  assign error_kind = res.error_kind;

`ifndef SYNTHESIS
  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_flag |->
      code_point == '0 && seq_length == LenNone && error_kind != KIND_NONE)
    else $error("error result with non-zero payload");

  a_ok_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error_flag |->
      error_kind == KIND_NONE && seq_length != LenNone && seq_length <= LenFour)
    else $error("good result with bad length or kind");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty result register");

  a_seq_state: assert property (@(posedge clk) disable iff (rst)
    bytes_left != 2'd0 |->
      exp_len >= LenTwo && {1'b0, bytes_left} < exp_len)
    else $error("sequence counters inconsistent");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_ready |=> skid_valid && $stable(skid))
    else $error("skid entry lost while output stalled");
`endif

endmodule

`default_nettype wire
